// ===== rtl/core/mono_framebuffer_pixel_writer_core_macros.svh =====
// Assertion macros used by the checker file of the frame store core.
`ifndef MONO_FRAMEBUFFER_PIXEL_WRITER_CORE_MACROS_SVH
`define MONO_FRAMEBUFFER_PIXEL_WRITER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MFPW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfpw assertion failed");

// Next-cycle implication, off while reset is high.
`define MFPW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfpw assertion failed");

// Next-cycle implication that stays armed through reset.
`define MFPW_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mfpw reset assertion failed");

`endif

// ===== rtl/core/mfpw_pkg.sv =====
`default_nettype none
package mfpw_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int ROW_MAX     = (MAX_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_MAX * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam int WIDTH_W = 8;
  localparam int HEIGHT_W = 7;
  localparam int ROWB_W  = WIDTH_W - 3 + 1;
  localparam int ACT_W   = ROWB_W + HEIGHT_W;
  localparam int DATA_W  = 8;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 3;

  typedef enum logic [1:0] {
    FN_DRAW = 2'd0,
    FN_FILL = 2'd1,
    FN_READ = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_ROT    = 3'd2,
    REG_FLIP_X = 3'd3,
    REG_FLIP_Y = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RMW,
    S_FILL
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               pixel_on;
    logic [9:0]         byte_index;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              accepted;
  } result_t;

  // Geometry as used by the datapath: width and height already clamped.
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [1:0]          rotation;
    logic                flip_x;
    logic                flip_y;
  } geom_cfg_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] mask;
  } pix_loc_t;

  function automatic logic [ROWB_W-1:0] row_bytes(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W:0] sum;
    sum = {1'b0, w} + (WIDTH_W+1)'(7);
    return sum[WIDTH_W:3];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mfpw_geom.sv =====
`default_nettype none
// Maps a logical pixel through the clip, mirror and rotation to a byte address and bit mask.
module mfpw_geom (
  input  mfpw_pkg::item_t    item,
  input  mfpw_pkg::geom_cfg_t cfg,
  output mfpw_pkg::pix_loc_t loc
);
  import mfpw_pkg::*;

  logic [WIDTH_W-1:0] w8, h8, lw, lh, x8, y8, fx, fy, px, py;
  logic               in_x, in_y;
  logic [ROWB_W-1:0]  rb;
  logic [WIDTH_W+ROWB_W-1:0] prod;
  logic [WIDTH_W+ROWB_W:0]   sum;

  always_comb begin
    w8 = cfg.width;
    h8 = {1'b0, cfg.height};
    lw = cfg.rotation[0] ? h8 : w8;
    lh = cfg.rotation[0] ? w8 : h8;
    in_x = !item.pos_x[15] && (item.pos_x[14:0] < {{(15-WIDTH_W){1'b0}}, lw});
    in_y = !item.pos_y[15] && (item.pos_y[14:0] < {{(15-WIDTH_W){1'b0}}, lh});
    x8 = item.pos_x[WIDTH_W-1:0];
    y8 = item.pos_y[WIDTH_W-1:0];
    fx = cfg.flip_x ? lw - x8 - WIDTH_W'(1) : x8;
    fy = cfg.flip_y ? lh - y8 - WIDTH_W'(1) : y8;
    unique case (cfg.rotation)
      ROT_90: begin
        px = w8 - fy - WIDTH_W'(1);
        py = fx;
      end
      ROT_180: begin
        px = w8 - fx - WIDTH_W'(1);
        py = h8 - fy - WIDTH_W'(1);
      end
      ROT_270: begin
        px = fy;
        py = h8 - fx - WIDTH_W'(1);
      end
      default: begin
        px = fx;
        py = fy;
      end
    endcase
    rb   = row_bytes(cfg.width);
    prod = py * rb;
    sum  = {1'b0, prod} + (WIDTH_W+ROWB_W+1)'(px[WIDTH_W-1:3]);
    loc.hit  = in_x && in_y && (sum < (WIDTH_W+ROWB_W+1)'(STORE_BYTES));
    loc.addr = sum[ADDR_W-1:0];
    loc.mask = 8'h80 >> px[2:0];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mfpw_store.sv =====
`default_nettype none
// Frame store: one write port, one read port with registered read data.
module mfpw_store (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [mfpw_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [mfpw_pkg::DATA_W-1:0]   wdata,
  input  wire logic                          re,
  input  wire logic [mfpw_pkg::ADDR_W-1:0]   raddr,
  output logic      [mfpw_pkg::DATA_W-1:0]   rdata
);
  import mfpw_pkg::*;

  logic [DATA_W-1:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mono_framebuffer_pixel_writer_core.sv =====
// Channel | Direction | Payload  | Handshake
// req     | in        | item_t   | req_valid / req_ready
// rsp     | out       | result_t | rsp_valid / rsp_ready
// cfg     | in        | cfg_data | cfg_we, cfg_index (no wait)
//
// Draw and read items pass through S_ADDR, which issues the store read, and then
// S_RMW, which modifies, writes back and loads the result register.
// A fill writes one active byte per cycle and loads its result at the last byte, once the
// result register is free; the next beat is then taken in S_IDLE. The write port sets the pace.
// After reset a clearing pass zeroes all STORE_BYTES (1024) bytes of the store; req_ready is low.
// A result not taken stalls the write-back stage; the store read data holds meanwhile.
`default_nettype none
module mono_framebuffer_pixel_writer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire mfpw_pkg::item_t               req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output mfpw_pkg::result_t                  rsp,
  input  wire logic                          cfg_we,
  input  wire logic [mfpw_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [mfpw_pkg::CFG_W-1:0]    cfg_data
);
  import mfpw_pkg::*;

  state_t    state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  item_t     item;
  geom_cfg_t cfg;
  pix_loc_t  loc;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              load, load_ok;
  logic [DATA_W-1:0] load_data;
  logic              can_load;

  logic [ACT_W-1:0]  active;
  logic [ADDR_W-1:0] fill_last;
  logic              read_ok;

  // Configuration; width and height are clamped as they are written.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= WIDTH_W'(MAX_WIDTH);
      cfg.height   <= HEIGHT_W'(MAX_HEIGHT);
      cfg.rotation <= ROT_0;
      cfg.flip_x   <= 1'b0;
      cfg.flip_y   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          if (cfg_data[WIDTH_W-1:0] == '0) begin
            cfg.width <= WIDTH_W'(1);
          end else if (cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) begin
            cfg.width <= WIDTH_W'(MAX_WIDTH);
          end else begin
            cfg.width <= cfg_data[WIDTH_W-1:0];
          end
        end
        REG_HEIGHT: begin
          if (cfg_data[HEIGHT_W-1:0] == '0) begin
            cfg.height <= HEIGHT_W'(1);
          end else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_HEIGHT)) begin
            cfg.height <= HEIGHT_W'(MAX_HEIGHT);
          end else begin
            cfg.height <= cfg_data[HEIGHT_W-1:0];
          end
        end
        REG_ROT:    cfg.rotation <= cfg_data[1:0];
        REG_FLIP_X: cfg.flip_x   <= cfg_data[0];
        REG_FLIP_Y: cfg.flip_y   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active = row_bytes(cfg.width) * cfg.height;
    if (active > ACT_W'(STORE_BYTES)) begin
      fill_last = ADDR_W'(STORE_BYTES - 1);
    end else begin
      fill_last = ADDR_W'(active - ACT_W'(1));
    end
    read_ok = (ACT_W'(item.byte_index) < active) &&
              (ACT_W'(item.byte_index) < ACT_W'(STORE_BYTES));
  end

  mfpw_geom u_geom (
    .item (item),
    .cfg  (cfg),
    .loc  (loc)
  );

  mfpw_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign can_load = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    req_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = loc.addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = loc.addr;
    load       = 1'b0;
    load_ok    = 1'b0;
    load_data  = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        cnt_next  = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(STORE_BYTES - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        case (item.func)
          FN_DRAW: begin
            mem_re     = 1'b1;
            state_next = S_RMW;
          end
          FN_READ: begin
            mem_re     = 1'b1;
            mem_raddr  = item.byte_index[ADDR_W-1:0];
            state_next = S_RMW;
          end
          FN_FILL: begin
            cnt_next   = '0;
            state_next = S_FILL;
          end
          default: state_next = S_RMW;
        endcase
      end
      S_RMW: begin
        if (can_load) begin
          load      = 1'b1;
          req_ready = 1'b1;
          if (item.func == FN_DRAW) begin
            load_ok   = loc.hit;
            mem_we    = loc.hit;
            mem_wdata = item.pixel_on ? (mem_rdata | loc.mask) : (mem_rdata & ~loc.mask);
          end else if (item.func == FN_READ) begin
            load_ok   = read_ok;
            load_data = read_ok ? mem_rdata : '0;
          end
          state_next = req_valid ? S_ADDR : S_IDLE;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = {DATA_W{item.pixel_on}};
        if (cnt == fill_last) begin
          // The last byte may be written again while the result waits; that is harmless.
          if (can_load) begin
            load       = 1'b1;
            load_ok    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (load) begin
      rsp.read_data <= load_data;
      rsp.accepted  <= load_ok;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mfpw_checker.sv =====
`default_nettype none
`include "mono_framebuffer_pixel_writer_core_macros.svh"
// Port-level checks on the frame store core.
module mfpw_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire mfpw_pkg::item_t    req,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire mfpw_pkg::result_t  rsp
);
  import mfpw_pkg::*;

  // Reset starts the clearing pass, so nothing is taken or offered right after it.
  `MFPW_ASSERT_RST(a_reset_quiet, rst, !req_ready && !rsp_valid)
  // An accepted beat always passes through S_ADDR before the next one is taken.
  `MFPW_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
  `MFPW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  // Stored data only comes back for an in-range read.
  `MFPW_ASSERT_NOW(a_data_needs_ok, rsp_valid && (rsp.read_data != '0), rsp.accepted)

endmodule

bind mono_framebuffer_pixel_writer_core mfpw_checker u_mfpw_checker (.*);
`default_nettype wire
